### hw/rtl/bsd_pkg.sv
// bsd_pkg: types, constants and the alphabet decode for the base58 stream decoder
// no dependencies; used by every file under hw/rtl
package bsd_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int CNT_W       = 7;
  localparam int RESULT_CAP  = 64;
  localparam int RADIX       = 58;
  localparam int DIGIT_W     = 6;

  localparam logic [7:0]         CHAR_ONE   = 8'h31;
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       final_byte;
  } out_word_t;

  // one entry of the command queue between front and back
  typedef struct packed {
    logic               absorb;
    logic [DIGIT_W-1:0] digit;
    logic               fin;
    status_t            err;
    logic [CNT_W-1:0]   lead;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ABS,
    BK_GROW,
    BK_FIN,
    BK_ERR,
    BK_ZERO,
    BK_BADDR,
    BK_BDATA
  } back_state_t;

  // bitcoin alphabet: digit value, or DIGIT_NONE outside the alphabet
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'hff;
    if (c >= 8'h31 && c <= 8'h39) d = c - 8'h31;            // 1..9
    else if (c >= 8'h41 && c <= 8'h48) d = c - 8'h41 + 8'd9;  // A..H
    else if (c >= 8'h4a && c <= 8'h4e) d = c - 8'h4a + 8'd17; // J..N
    else if (c >= 8'h50 && c <= 8'h5a) d = c - 8'h50 + 8'd22; // P..Z
    else if (c >= 8'h61 && c <= 8'h6b) d = c - 8'h61 + 8'd33; // a..k
    else if (c >= 8'h6d && c <= 8'h7a) d = c - 8'h6d + 8'd44; // m..z
    if (d == 8'hff) return DIGIT_NONE;
    return d[DIGIT_W-1:0];
  endfunction

endpackage

### hw/rtl/bsd_front.sv
// bsd_front: takes input words, tracks leading ones, length and errors, issues commands
// depends on bsd_pkg
module bsd_front #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  bsd_pkg::in_word_t in_word,
  output logic              cmd_push,
  output bsd_pkg::cmd_t     cmd
);

  localparam logic [bsd_pkg::CNT_W-1:0] MAX_CNT = bsd_pkg::CNT_W'(MAX_SYMBOLS);

  logic [bsd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [bsd_pkg::CNT_W-1:0]   lead_r, lead_nxt;
  logic                        run_r, run_nxt;
  bsd_pkg::status_t            err_r, err_nxt;
  logic [bsd_pkg::DIGIT_W-1:0] digit;
  logic                        absorb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lead_r <= '0;
      run_r  <= 1'b1;
      err_r  <= bsd_pkg::ST_OK;
    end else begin
      cnt_r  <= cnt_nxt;
      lead_r <= lead_nxt;
      run_r  <= run_nxt;
      err_r  <= err_nxt;
    end
  end

  always_comb begin
    digit    = bsd_pkg::digit_of(in_word.symbol);
    cnt_nxt  = cnt_r;
    lead_nxt = lead_r;
    run_nxt  = run_r;
    err_nxt  = err_r;
    absorb   = 1'b0;
    if (accept) begin
      if (cnt_r >= MAX_CNT) begin
        if (err_r == bsd_pkg::ST_OK) err_nxt = bsd_pkg::ST_TOO_LONG;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (err_r == bsd_pkg::ST_OK) begin
          if (run_r && in_word.symbol == bsd_pkg::CHAR_ONE) begin
            lead_nxt = lead_r + 1'b1;
          end else begin
            run_nxt = 1'b0;
            if (digit == bsd_pkg::DIGIT_NONE) err_nxt = bsd_pkg::ST_BAD_CHAR;
            else absorb = 1'b1;
          end
        end
      end
    end
    cmd_push   = accept && (absorb || in_word.final_symbol);
    cmd.absorb = absorb;
    cmd.digit  = digit;
    cmd.fin    = in_word.final_symbol;
    cmd.err    = err_nxt;
    cmd.lead   = lead_nxt;
    // string done: back to reset state for the next one
    if (accept && in_word.final_symbol) begin
      cnt_nxt  = '0;
      lead_nxt = '0;
      run_nxt  = 1'b1;
      err_nxt  = bsd_pkg::ST_OK;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAX_CNT)
    else $error("symbol count beyond limit");

endmodule

### hw/rtl/bsd_cmd_fifo.sv
// bsd_cmd_fifo: short command queue between front and back
// depends on bsd_pkg
module bsd_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsd_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output bsd_pkg::cmd_t rd_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  bsd_pkg::cmd_t     entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign avail   = (count_r != '0);
  assign rd_cmd  = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= wr_cmd;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("command pushed into full queue");

endmodule

### hw/rtl/bsd_back.sv
// bsd_back: byte store walk (times 58 plus digit) and result emission
// depends on bsd_pkg
module bsd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_avail,
  input  bsd_pkg::cmd_t      cmd_in,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output bsd_pkg::out_word_t out_word
);

  localparam int CW = bsd_pkg::CNT_W;
  localparam int AW = bsd_pkg::ADDR_W;
  localparam int DW = bsd_pkg::DIGIT_W;
  localparam logic [CW-1:0] DEPTH_C  = CW'(bsd_pkg::STORE_DEPTH);
  localparam logic [CW-1:0] CAP_LAST = CW'(bsd_pkg::RESULT_CAP - 1);
  localparam logic [CW-1:0] ONE_C    = CW'(1);

  bsd_pkg::back_state_t state_r, state_nxt;
  bsd_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [CW-1:0]        len_r, len_nxt;
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]        wr_idx_r, wr_idx_nxt;
  logic                 vld_r, vld_nxt;
  logic [DW-1:0]        carry_r, carry_nxt;
  logic [CW-1:0]        zl_r, zl_nxt;
  logic [CW-1:0]        bl_r, bl_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 out_valid_r;
  bsd_pkg::out_word_t   out_word_r;

  logic [7:0]           mem [bsd_pkg::STORE_DEPTH];
  logic [7:0]           rdata_r;
  logic                 we, rd_en, load, slot_free, last;
  logic [AW-1:0]        waddr, raddr;
  logic [7:0]           wdata;
  logic [13:0]          acc;
  logic [CW-1:0]        bl_dec;
  bsd_pkg::out_word_t   load_word;

  assign slot_free = !out_valid_r || pop;
  assign empty     = !out_valid_r;
  assign out_word  = out_word_r;
  assign acc       = 14'(rdata_r) * 14'(bsd_pkg::RADIX) + 14'(carry_r);
  assign bl_dec    = bl_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsd_pkg::BK_IDLE;
      len_r       <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      vld_r   <= vld_nxt;
      if (load)     out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    rd_idx_r <= rd_idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    carry_r  <= carry_nxt;
    zl_r     <= zl_nxt;
    bl_r     <= bl_nxt;
    cnt_r    <= cnt_nxt;
    if (load) out_word_r <= load_word;
  end

  // byte store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we)    mem[waddr] <= wdata;
    if (rd_en) rdata_r    <= mem[raddr];
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    vld_nxt    = vld_r;
    carry_nxt  = carry_r;
    zl_nxt     = zl_r;
    bl_nxt     = bl_r;
    cnt_nxt    = cnt_r;
    cmd_pop    = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    rd_en      = 1'b0;
    raddr      = '0;
    load       = 1'b0;
    last       = 1'b0;
    load_word  = '{out_byte: 8'h00, status: bsd_pkg::ST_OK, final_byte: 1'b0};
    unique case (state_r)
      bsd_pkg::BK_IDLE: begin
        if (cmd_avail) begin
          cmd_pop    = 1'b1;
          cmd_nxt    = cmd_in;
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          vld_nxt    = 1'b0;
          carry_nxt  = cmd_in.digit;
          if (!cmd_in.absorb)    state_nxt = bsd_pkg::BK_FIN;
          else if (len_r == '0)  state_nxt = bsd_pkg::BK_GROW;
          else                   state_nxt = bsd_pkg::BK_ABS;
        end
      end
      bsd_pkg::BK_ABS: begin
        // read of byte i+1 overlaps the write of byte i
        vld_nxt = 1'b0;
        if (rd_idx_r < len_r) begin
          rd_en      = 1'b1;
          raddr      = rd_idx_r[AW-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
          vld_nxt    = 1'b1;
        end
        if (vld_r) begin
          we         = 1'b1;
          waddr      = wr_idx_r[AW-1:0];
          wdata      = acc[7:0];
          carry_nxt  = acc[13:8];
          wr_idx_nxt = wr_idx_r + 1'b1;
          if (wr_idx_r == len_r - 1'b1) begin
            state_nxt = bsd_pkg::BK_GROW;
            vld_nxt   = 1'b0;
          end
        end
      end
      bsd_pkg::BK_GROW: begin
        // carry stays below 58, so at most one new byte
        if (carry_r != '0 && len_r < DEPTH_C) begin
          we      = 1'b1;
          waddr   = len_r[AW-1:0];
          wdata   = 8'(carry_r);
          len_nxt = len_r + 1'b1;
        end
        state_nxt = cmd_r.fin ? bsd_pkg::BK_FIN : bsd_pkg::BK_IDLE;
      end
      bsd_pkg::BK_FIN: begin
        zl_nxt  = cmd_r.lead;
        bl_nxt  = len_r;
        cnt_nxt = '0;
        if (cmd_r.err != bsd_pkg::ST_OK) state_nxt = bsd_pkg::BK_ERR;
        else if (cmd_r.lead != '0)       state_nxt = bsd_pkg::BK_ZERO;
        else if (len_r != '0)            state_nxt = bsd_pkg::BK_BADDR;
        else                             state_nxt = bsd_pkg::BK_IDLE;
      end
      bsd_pkg::BK_ERR: begin
        if (slot_free) begin
          load      = 1'b1;
          load_word = '{out_byte: 8'h00, status: cmd_r.err, final_byte: 1'b1};
          len_nxt   = '0;
          state_nxt = bsd_pkg::BK_IDLE;
        end
      end
      bsd_pkg::BK_ZERO: begin
        if (slot_free) begin
          last      = (cnt_r == CAP_LAST) || (zl_r == ONE_C && bl_r == '0);
          load      = 1'b1;
          load_word = '{out_byte: 8'h00, status: bsd_pkg::ST_OK, final_byte: last};
          zl_nxt    = zl_r - 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          if (last) begin
            len_nxt   = '0;
            state_nxt = bsd_pkg::BK_IDLE;
          end else if (zl_r == ONE_C) begin
            state_nxt = bsd_pkg::BK_BADDR;
          end
        end
      end
      bsd_pkg::BK_BADDR: begin
        rd_en     = 1'b1;
        raddr     = bl_dec[AW-1:0];
        state_nxt = bsd_pkg::BK_BDATA;
      end
      bsd_pkg::BK_BDATA: begin
        if (slot_free) begin
          last      = (cnt_r == CAP_LAST) || (bl_r == ONE_C);
          load      = 1'b1;
          load_word = '{out_byte: rdata_r, status: bsd_pkg::ST_OK, final_byte: last};
          bl_nxt    = bl_dec;
          cnt_nxt   = cnt_r + 1'b1;
          if (last) begin
            len_nxt   = '0;
            state_nxt = bsd_pkg::BK_IDLE;
          end else begin
            state_nxt = bsd_pkg::BK_BADDR;
          end
        end
      end
      default: state_nxt = bsd_pkg::BK_IDLE;
    endcase
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n) len_r <= DEPTH_C)
    else $error("store length beyond depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsd_pkg::BK_ABS && we) |-> (wr_idx_r < len_r))
    else $error("store walk writes past its length");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsd_pkg::BK_ERR && slot_free) |=>
      (out_valid_r && out_word_r.final_byte && out_word_r.status != bsd_pkg::ST_OK))
    else $error("error result not marked final with error status");

endmodule

### hw/rtl/base58_stream_decoder_unit.sv
// base58_stream_decoder_unit: top level, base58 (bitcoin alphabet) decoder for a character stream
// depends on bsd_pkg, bsd_front, bsd_cmd_fifo, bsd_back
// a leading '1', bad or excess character stays in the front unless it is the last one; a digit
//   walks the byte store in the back (times 58 plus carry), one store byte a cycle
// output: on the last character, one zero byte per cycle while the output register is free,
//   then each stored byte passes an address state and a data state (registered store read)
// reset: synchronous active-low rst_n clears control and queues; store contents are not cleared
module base58_stream_decoder_unit #(
  parameter int MAX_SYMBOLS = 64,
  parameter int CMD_DEPTH   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // input word channel
  input  logic               push,
  output logic               full,
  input  bsd_pkg::in_word_t  in_word,
  // result word channel
  output logic               empty,
  input  logic               pop,
  output bsd_pkg::out_word_t out_word
);

  // front to queue
  logic          accept;
  logic          cmd_push;
  bsd_pkg::cmd_t cmd_wr;
  // queue to back
  logic          cmd_avail;
  logic          cmd_pop;
  bsd_pkg::cmd_t cmd_rd;

  // a word is taken whenever the command queue has room
  assign accept = push && !full;

  // front: leading ones, symbol count, first error wins
  bsd_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_word),
    .cmd_push (cmd_push),
    .cmd      (cmd_wr)
  );

  // short queue so the front keeps taking words during a store walk
  bsd_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd_wr),
    .full   (full),
    .pop    (cmd_pop),
    .avail  (cmd_avail),
    .rd_cmd (cmd_rd)
  );

  // back: multiply-accumulate over the byte store, then emit with an output register
  bsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_avail (cmd_avail),
    .cmd_in    (cmd_rd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

endmodule
